// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros. Each expects clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ES_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("es assertion failed");

// Next-cycle implication.
`define ES_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("es assertion failed");

`endif

// ===== rtl/core/es_pkg.sv =====
package es_pkg;

    localparam int FRAC_BITS_DEF = 28;
    localparam int COORD_W = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [63:0] PI_HALF_Q62 = 64'h6487ED5110B4611A;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_DEGEN = 2'd1,
        STATUS_SAT   = 2'd2
    } es_status_t;

    typedef enum logic {
        CFG_Y_UPPER = 1'b0,
        CFG_Y_LOWER = 1'b1
    } es_cfg_index_t;

    typedef struct packed {
        logic pole;
        logic degen;
        logic over;
    } es_flags_t;

    // Width of the snapped right-point y, wide enough for pi/2 at any fraction width.
    function automatic int es_snap_w(input int frac_bits);
        return (frac_bits + 3 > COORD_W) ? frac_bits + 3 : COORD_W;
    endfunction

endpackage

// ===== rtl/core/edge_skewness_core.sv =====
// Edge skewness core: one mesh edge in, one skewness result out.
// Input channel in_valid/in_ready carries the edge nodes, both centroids and the
// pole and boundary flags; output channel out_valid/out_ready carries skew_value
// (Q3.28 by default) and status (ok, degenerate, saturated).
// Configuration writes on cfg_we/cfg_index/cfg_data set the latitude bounds used
// to snap the right point of a boundary edge to +/- pi/2; write them while idle.
// Throughput is one transaction per cycle while out_ready stays high. A front
// stage snaps and forms the coordinate differences, a four-entry queue decouples
// it from the back pipeline, which has the product, subtract, magnitude and
// range-check stages, then one restoring-division stage per quotient bit (33 bits
// up to 31 fraction bits, FRAC_BITS + 2 above), then the output register.
// At the default Q3.28 format the quotient is 33 bits wide, and every result
// passes through the whole division chain before the output register.
// Reset clears all valid flags and loads the default bounds; no pass is needed.
// When out_ready is low with out_valid high the back pipeline holds, the queue
// fills, and in_ready drops only once the queue and front stage are both full.
module edge_skewness_core
    import es_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [COORD_W-1:0]        cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      pole_edge,
    input  logic                      boundary_edge,
    input  logic signed [COORD_W-1:0] first_node_x,
    input  logic signed [COORD_W-1:0] first_node_y,
    input  logic signed [COORD_W-1:0] second_node_x,
    input  logic signed [COORD_W-1:0] second_node_y,
    input  logic signed [COORD_W-1:0] left_center_x,
    input  logic signed [COORD_W-1:0] left_center_y,
    input  logic signed [COORD_W-1:0] right_center_x,
    input  logic signed [COORD_W-1:0] right_center_y,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] skew_value,
    output logic [1:0]                status
);

    localparam int DW = es_snap_w(FRAC_BITS) + 1;
    localparam int QDW = 1 + 6 * DW;

    logic           f_valid, f_ready;
    logic [QDW-1:0] f_data;
    logic           q_valid, q_ready;
    logic [QDW-1:0] q_data;

    es_front #(.FRAC_BITS(FRAC_BITS), .DW(DW), .QDW(QDW)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pole_edge      (pole_edge),
        .boundary_edge  (boundary_edge),
        .first_node_x   (first_node_x),
        .first_node_y   (first_node_y),
        .second_node_x  (second_node_x),
        .second_node_y  (second_node_y),
        .left_center_x  (left_center_x),
        .left_center_y  (left_center_y),
        .right_center_x (right_center_x),
        .right_center_y (right_center_y),
        .f_valid        (f_valid),
        .f_ready        (f_ready),
        .f_data         (f_data)
    );

    es_queue #(.WIDTH(QDW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    es_back #(.FRAC_BITS(FRAC_BITS), .DW(DW), .QDW(QDW)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .skew_value (skew_value),
        .status     (status)
    );

endmodule

// ===== rtl/core/es_front.sv =====
module es_front
    import es_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int DW = es_snap_w(FRAC_BITS) + 1,
    parameter int QDW = 1 + 6 * DW
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [COORD_W-1:0]        cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      pole_edge,
    input  logic                      boundary_edge,
    input  logic signed [COORD_W-1:0] first_node_x,
    input  logic signed [COORD_W-1:0] first_node_y,
    input  logic signed [COORD_W-1:0] second_node_x,
    input  logic signed [COORD_W-1:0] second_node_y,
    input  logic signed [COORD_W-1:0] left_center_x,
    input  logic signed [COORD_W-1:0] left_center_y,
    input  logic signed [COORD_W-1:0] right_center_x,
    input  logic signed [COORD_W-1:0] right_center_y,
    output logic                      f_valid,
    input  logic                      f_ready,
    output logic [QDW-1:0]            f_data
);

    localparam int SW = DW - 1;
    localparam logic [63:0] TOL = ((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] HALF_PI =
        (PI_HALF_Q62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);

    logic signed [COORD_W-1:0] y_upper_reg, y_upper_next;
    logic signed [COORD_W-1:0] y_lower_reg, y_lower_next;
    logic                      vld_reg, vld_next;
    logic [QDW-1:0]            data_reg, data_next;

    logic signed [COORD_W:0]   du, dl;
    logic [COORD_W:0]          du_mag, dl_mag;
    logic                      snap_up, snap_dn;
    logic signed [SW-1:0]      yc2;
    logic signed [DW-1:0]      ex, ey, cx, cy, ox, oy;
    logic                      accept;

    assign in_ready = !vld_reg || f_ready;
    assign accept   = in_valid && in_ready;
    assign f_valid  = vld_reg;
    assign f_data   = data_reg;

    always_comb
    begin
        y_upper_next = y_upper_reg;
        y_lower_next = y_lower_reg;
        if (cfg_we)
        begin
            case (es_cfg_index_t'(cfg_index))
                CFG_Y_UPPER: y_upper_next = cfg_data;
                CFG_Y_LOWER: y_lower_next = cfg_data;
                default:     y_upper_next = y_upper_reg;
            endcase
        end
    end

    always_comb
    begin
        du      = (COORD_W + 1)'(right_center_y) - (COORD_W + 1)'(y_upper_reg);
        dl      = (COORD_W + 1)'(right_center_y) - (COORD_W + 1)'(y_lower_reg);
        du_mag  = du[COORD_W] ? (COORD_W + 1)'(-du) : (COORD_W + 1)'(du);
        dl_mag  = dl[COORD_W] ? (COORD_W + 1)'(-dl) : (COORD_W + 1)'(dl);
        snap_up = boundary_edge && (64'(du_mag) < TOL);
        snap_dn = boundary_edge && (64'(dl_mag) < TOL);
        if (snap_up)
        begin
            yc2 = signed'(HALF_PI[SW-1:0]);
        end
        else if (snap_dn)
        begin
            yc2 = -signed'(HALF_PI[SW-1:0]);
        end
        else
        begin
            yc2 = SW'(right_center_y);
        end
        ex = DW'(second_node_x) - DW'(first_node_x);
        ey = DW'(second_node_y) - DW'(first_node_y);
        cx = DW'(right_center_x) - DW'(left_center_x);
        cy = DW'(yc2) - DW'(left_center_y);
        ox = DW'(left_center_x) - DW'(first_node_x);
        oy = DW'(left_center_y) - DW'(first_node_y);
        data_next = {pole_edge, ex, cy, ey, cx, ox, oy};
        vld_next  = (vld_reg && !f_ready) || accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y_upper_reg <= 32'sd421657428;
            y_lower_reg <= -32'sd421657428;
            vld_reg     <= 1'b0;
        end
        else
        begin
            y_upper_reg <= y_upper_next;
            y_lower_reg <= y_lower_next;
            vld_reg     <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/es_queue.sv =====
`include "assert_macros.svh"

module es_queue
    import es_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = cnt_reg != CW'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    `ES_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= CW'(DEPTH))
    `ES_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_reg == CW'($past(cnt_reg) + 1'b1))

endmodule

// ===== rtl/core/es_back.sv =====
`include "assert_macros.svh"

module es_back
    import es_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int DW = es_snap_w(FRAC_BITS) + 1,
    parameter int QDW = 1 + 6 * DW
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  logic [QDW-1:0]            q_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] skew_value,
    output logic [1:0]                status
);

    localparam int PW = 2 * DW;
    localparam int MW = PW + 1;
    localparam int QW = ((FRAC_BITS > 31) ? FRAC_BITS : 31) + 2;
    localparam int RW = MW + QW;
    localparam int PRE_SH = QW - FRAC_BITS - 1;
    localparam logic [QW-1:0] ONE_Q = QW'(64'd1 << FRAC_BITS);
    localparam logic [QW-1:0] CAP = QW'((64'd1 << FRAC_BITS) + 64'h80000000);
    localparam logic signed [QW:0] S_MAX = (QW + 1)'(64'sd2147483647);
    localparam logic signed [QW:0] S_MIN = (QW + 1)'(-64'sd2147483648);

    logic en;

    logic signed [DW-1:0] ex, cy, ey, cx, ox, oy;

    logic                 v0_reg, v1_reg, v2_reg;
    es_flags_t            f0_reg, f1_reg, f2_reg;
    es_flags_t            f0_next, f1_next, f2_next;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [PW-1:0] p1_next, p2_next, p3_next, p4_next;
    logic signed [MW-1:0] num_reg, den_reg, num_next, den_next;
    logic [MW-1:0]        nm_reg, dm2_reg, nm_next, dm2_next;

    logic                 vd_reg [0:QW];
    es_flags_t            fd_reg [0:QW];
    logic [RW-1:0]        rem_reg [0:QW];
    logic [QW-1:0]        q_reg [0:QW];
    logic [MW-1:0]        dm_reg [0:QW];
    es_flags_t            fd0_next;
    logic [RW-1:0]        rem0_next;

    logic                 out_vld_reg;
    logic signed [COORD_W-1:0] skew_reg, skew_next;
    es_status_t           status_reg, status_next;

    logic                 over;
    logic signed [QW:0]   skew_w;

    assign en        = !out_vld_reg || out_ready;
    assign q_ready   = en;
    assign out_valid = out_vld_reg;
    assign skew_value = skew_reg;
    assign status    = status_reg;

    assign {ex, cy, ey, cx, ox, oy} = q_data[QDW-2:0];

    always_comb
    begin
        f0_next       = '0;
        f0_next.pole  = q_data[QDW-1];
        p1_next       = PW'(ex) * PW'(cy);
        p2_next       = PW'(ey) * PW'(cx);
        p3_next       = PW'(ox) * PW'(cy);
        p4_next       = PW'(oy) * PW'(cx);

        f1_next       = f0_reg;
        den_next      = MW'(p1_reg) - MW'(p2_reg);
        num_next      = MW'(p3_reg) - MW'(p4_reg);

        f2_next       = f1_reg;
        f2_next.degen = den_reg == '0;
        nm_next       = num_reg[MW-1] ? MW'(-num_reg) : MW'(num_reg);
        dm2_next      = den_reg[MW-1] ? MW'(-den_reg) : MW'(den_reg);

        fd0_next      = f2_reg;
        fd0_next.over = (RW'(nm_reg) >= (RW'(dm2_reg) << PRE_SH));
        rem0_next     = RW'(nm_reg) << (FRAC_BITS + 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f0_reg     <= f0_next;
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
            p3_reg     <= p3_next;
            p4_reg     <= p4_next;
            f1_reg     <= f1_next;
            den_reg    <= den_next;
            num_reg    <= num_next;
            f2_reg     <= f2_next;
            nm_reg     <= nm_next;
            dm2_reg    <= dm2_next;
            fd_reg[0]  <= fd0_next;
            rem_reg[0] <= rem0_next;
            q_reg[0]   <= '0;
            dm_reg[0]  <= dm2_reg;
            skew_reg   <= skew_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            vd_reg[0]   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg      <= q_valid;
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            vd_reg[0]   <= v2_reg;
            out_vld_reg <= vd_reg[QW];
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        localparam int B = QW - 1 - j;
        logic [RW-1:0] sh;
        logic          ge;
        logic [RW-1:0] rem_next;
        logic [QW-1:0] q_next;

        assign sh       = RW'(dm_reg[j]) << B;
        assign ge       = rem_reg[j] >= sh;
        assign rem_next = ge ? rem_reg[j] - sh : rem_reg[j];
        assign q_next   = q_reg[j] | (QW'(ge) << B);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= rem_next;
                q_reg[j+1]   <= q_next;
                dm_reg[j+1]  <= dm_reg[j];
                fd_reg[j+1]  <= fd_reg[j];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vd_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vd_reg[j+1] <= vd_reg[j];
            end
        end
    end

    always_comb
    begin
        over   = fd_reg[QW].over || (q_reg[QW] > CAP);
        skew_w = signed'({1'b0, ONE_Q}) - signed'({1'b0, q_reg[QW]});
        if (fd_reg[QW].pole)
        begin
            skew_next   = '0;
            status_next = STATUS_OK;
        end
        else if (fd_reg[QW].degen)
        begin
            skew_next   = '0;
            status_next = STATUS_DEGEN;
        end
        else if (over || (skew_w < S_MIN))
        begin
            skew_next   = 32'sh80000000;
            status_next = STATUS_SAT;
        end
        else if (skew_w > S_MAX)
        begin
            skew_next   = 32'sh7FFFFFFF;
            status_next = STATUS_SAT;
        end
        else
        begin
            skew_next   = skew_w[COORD_W-1:0];
            status_next = STATUS_OK;
        end
    end

    `ES_ASSERT_IMPL(a_degen_zero, out_vld_reg && (status_reg == STATUS_DEGEN), skew_reg == '0)
    `ES_ASSERT_IMPL(a_sat_end, out_vld_reg && (status_reg == STATUS_SAT), (skew_reg == 32'sh7FFFFFFF) || (skew_reg == 32'sh80000000))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import es_pkg::*;
();

    typedef struct {
        logic               pole;
        logic               boundary;
        logic signed [31:0] x1, y1, x2, y2, lx, ly, rx, ry;
    } edge_item_t;

    typedef struct {
        logic signed [31:0] skew;
        es_status_t         stat;
    } skew_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic                      cfg_index;
    logic [COORD_W-1:0]        cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      pole_edge;
    logic                      boundary_edge;
    logic signed [COORD_W-1:0] first_node_x, first_node_y, second_node_x, second_node_y;
    logic signed [COORD_W-1:0] left_center_x, left_center_y, right_center_x, right_center_y;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [COORD_W-1:0] skew_value;
    logic [1:0]                status;

    longint       upper_bound;
    longint       lower_bound;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           mismatch_count;
    skew_result_t expected_skews[$];

    localparam longint SNAP_TOL = ((64'd1 << 28) + 64'd500000) / 64'd1000000;
    localparam longint HALF_PI = (PI_HALF_Q62 + (64'd1 << 33)) >> 34;

    edge_skewness_core DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic skew_result_t predict_skew(edge_item_t e);
        skew_result_t       r;
        longint             yc2, du, dl;
        logic signed [127:0] ex, ey, cx, cy, ox, oy, den, num;
        logic [127:0]       an, ad, q;
        r.skew = 0;
        r.stat = STATUS_OK;
        if (e.pole)
            return r;
        yc2 = e.ry;
        if (e.boundary)
        begin
            du = yc2 - upper_bound;
            dl = yc2 - lower_bound;
            if ((du < 0 ? -du : du) < SNAP_TOL)
                yc2 = HALF_PI;
            else if ((dl < 0 ? -dl : dl) < SNAP_TOL)
                yc2 = -HALF_PI;
        end
        ex = longint'(e.x2) - longint'(e.x1);
        ey = longint'(e.y2) - longint'(e.y1);
        cx = longint'(e.rx) - longint'(e.lx);
        cy = yc2 - longint'(e.ly);
        ox = longint'(e.lx) - longint'(e.x1);
        oy = longint'(e.ly) - longint'(e.y1);
        den = ex * cy - ey * cx;
        num = ox * cy - oy * cx;
        if (den == 0)
        begin
            r.stat = STATUS_DEGEN;
            return r;
        end
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        q = (an << 29) / ad;
        if (q > (128'd1 << 28) + 128'h80000000)
        begin
            r.skew = 32'sh80000000;
            r.stat = STATUS_SAT;
        end
        else
            r.skew = 32'((128'd1 << 28) - q);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        skew_result_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_skews.size() == 0)
                report_mismatch("unexpected transaction", skew_value, 0);
            else
            begin
                w = expected_skews.pop_front();
                if (skew_value !== w.skew)
                    report_mismatch("skew_value", skew_value, w.skew);
                if (status !== w.stat)
                    report_mismatch("status", status, w.stat);
            end
        end
    end

    task automatic send_edge(edge_item_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        pole_edge     <= e.pole;
        boundary_edge <= e.boundary;
        first_node_x  <= e.x1;
        first_node_y  <= e.y1;
        second_node_x <= e.x2;
        second_node_y <= e.y2;
        left_center_x <= e.lx;
        left_center_y <= e.ly;
        right_center_x <= e.rx;
        right_center_y <= e.ry;
        do @(posedge clk); while (!in_ready);
        expected_skews = {expected_skews, predict_skew(e)};
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_skews.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_bound(es_cfg_index_t idx, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_Y_UPPER)
            upper_bound = longint'($signed(value));
        else
            lower_bound = longint'($signed(value));
    endtask

    function automatic edge_item_t make_edge(logic p, logic b, int a, int c, int d, int f,
                                             int g, int h, int i, int j);
        edge_item_t e;
        e.pole = p; e.boundary = b;
        e.x1 = a; e.y1 = c; e.x2 = d; e.y2 = f; e.lx = g; e.ly = h; e.rx = i; e.ry = j;
        return e;
    endfunction

    function automatic int rand_coord(int span);
        if (span == 0)
            return $urandom;
        return $urandom_range(2 * span) - span;
    endfunction

    function automatic edge_item_t random_edge();
        edge_item_t e;
        int span, k, bnd;
        k = $urandom_range(99);
        span = (k < 10) ? 0 : (k < 30) ? 16 : (1 << $urandom_range(4, 29));
        e.pole = ($urandom_range(99) < 8);
        e.boundary = ($urandom_range(99) < 35);
        e.x1 = rand_coord(span); e.y1 = rand_coord(span);
        e.x2 = rand_coord(span); e.y2 = rand_coord(span);
        e.lx = rand_coord(span); e.ly = rand_coord(span);
        e.rx = rand_coord(span); e.ry = rand_coord(span);
        k = $urandom_range(99);
        if (e.boundary && k < 40)
        begin
            bnd = ($urandom_range(1)) ? upper_bound : lower_bound;
            e.ry = bnd + $urandom_range(600) - 300;
        end
        else if (k < 50)
        begin
            e.rx = e.lx + (e.x2 - e.x1);
            e.ry = e.ly + (e.y2 - e.y1);
        end
        else if (k < 55)
        begin
            e.x2 = e.x1;
            e.y2 = e.y1;
        end
        return e;
    endfunction

    task automatic test_directed();
        send_edge(make_edge(1, 0, 5, 6, 7, 8, 9, 10, 11, 12));
        send_edge(make_edge(1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_edge(make_edge(0, 0, 0, 0, 1 << 28, 0, 1 << 27, -(1 << 27), 1 << 27, 1 << 27));
        send_edge(make_edge(0, 0, 0, 0, 1 << 28, 0, 0, -(1 << 27), 1 << 28, 1 << 27));
        send_edge(make_edge(0, 0, 5, 5, 5, 5, 1, 2, 3, 4));
        send_edge(make_edge(0, 0, 0, 0, 10, 0, 0, 1, 10, 1));
        send_edge(make_edge(0, 0, 0, 0, 1, 0, 1 << 30, -1, 1 << 30, 1));
        send_edge(make_edge(0, 0, 0, 0, 1, 0, -(1 << 30), -1, -(1 << 30), 1));
        send_edge(make_edge(0, 1, 0, 0, 1 << 28, 0, 1 << 27, -(1 << 27), 1 << 27,
                            421657428 + 100));
        send_edge(make_edge(0, 1, 0, 0, 1 << 28, 0, 1 << 27, 1 << 27, 1 << 27,
                            -421657428 - 100));
        send_edge(make_edge(0, 1, 0, 0, 1 << 28, 0, 1 << 27, -(1 << 27), 1 << 27,
                            421657428 + 268));
        send_edge(make_edge(0, 1, 0, 0, 1 << 28, 0, 1 << 27, -(1 << 27), 1 << 27,
                            421657428 - 267));
        send_edge(make_edge(0, 1, 0, 0, 1 << 28, 0, 1 << 27, 1 << 27, 1 << 27,
                            -421657428 - 268));
        send_edge(make_edge(0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                            32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
        send_edge(make_edge(0, 1, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                            32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000));
        send_edge(make_edge(0, 0, -1, -1, -1, -1, -1, -1, -1, -1));
        wait_drained();
    endtask

    task automatic test_bound_extremes();
        write_bound(CFG_Y_UPPER, 32'h7fffffff);
        write_bound(CFG_Y_LOWER, 32'h80000000);
        send_edge(make_edge(0, 1, 0, 0, 1 << 28, 0, 1 << 27, -(1 << 27), 1 << 27,
                            32'h7fffff00));
        send_edge(make_edge(0, 1, 0, 0, 1 << 28, 0, 1 << 27, 1 << 27, 1 << 27,
                            32'h80000010));
        send_edge(make_edge(0, 1, 0, 0, 1 << 28, 0, 1 << 27, 1 << 27, 1 << 27,
                            32'h80000200));
        wait_drained();
    endtask

    task automatic test_random(int count);
        int phase, n;
        for (phase = 0; phase < 4; phase++)
        begin
            case ($urandom_range(2))
                0:
                begin
                    write_bound(CFG_Y_UPPER, 421657428);
                    write_bound(CFG_Y_LOWER, -421657428);
                end
                1:
                begin
                    write_bound(CFG_Y_UPPER, $urandom);
                    write_bound(CFG_Y_LOWER, $urandom);
                end
                default:
                begin
                    write_bound(CFG_Y_UPPER, 32'h80000000);
                    write_bound(CFG_Y_LOWER, 32'h7fffffff);
                end
            endcase
            send_idle_pct  = (phase == 1) ? 66 : (phase == 3) ? 6 : 0;
            recv_stall_pct = (phase == 2) ? 66 : (phase == 3) ? 6 : 0;
            for (n = 0; n < count / 4; n++)
                send_edge(random_edge());
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        in_valid = 1'b0; pole_edge = 1'b0; boundary_edge = 1'b0;
        first_node_x = '0; first_node_y = '0; second_node_x = '0; second_node_y = '0;
        left_center_x = '0; left_center_y = '0; right_center_x = '0; right_center_y = '0;
        out_ready = 1'b0;
        upper_bound = 421657428;
        lower_bound = -421657428;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_bound_extremes();
        test_random(1700);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/es_pkg.sv
rtl/core/es_front.sv
rtl/core/es_queue.sv
rtl/core/es_back.sv
rtl/core/edge_skewness_core.sv
tb/testbench.sv
